### src/dcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance constraint solver package
// Shared widths, the item context carried down the pipeline and the step
// functions used by the square root, divider and fixed-point product stages.
// ----------------------------------------------------------------------------
package dcs_pkg;

    // Q30 unity and the equal-split weight.
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30 = 31'h2000_0000;

    // Near-zero distance limit (0.0001 as Q16.16) squared, and the nudge (0.0002).
    localparam logic [66:0] NEAR_SQ    = 67'd49;
    localparam logic [33:0] NEAR_LIMIT = 34'd7;
    localparam logic [33:0] NUDGE_STEP = 34'd13;

    // Square root: radicand width and number of root bits.
    localparam int RAD_W     = 67;
    localparam int ROOT_BITS = 34;
    // Divider: quotient bits after the integer bit.
    localparam int DIV_STEPS = 30;

    // Stream widths.
    localparam int IN_DATA_W  = 320;
    localparam int OUT_DATA_W = 256;

    // Pipeline stage numbering.
    localparam int ST_A    = 0;
    localparam int ST_B    = 1;
    localparam int ST_C    = 2;
    localparam int ST_Q0   = 3;
    localparam int ST_DL   = ST_Q0 + ROOT_BITS;
    localparam int ST_P0   = ST_DL + DIV_STEPS + 1;
    localparam int N_STAGE = ST_P0 + 6;

    // Item context that travels with every stage.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [32:0] p2y;
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic [30:0]        len;
        logic [15:0]        m1;
        logic [15:0]        m2;
        logic signed [32:0] dx;
        logic signed [33:0] dy;
    } ctx_t;

    // Square root partial result.
    typedef struct packed {
        logic [RAD_W-1:0]     rem;
        logic [ROOT_BITS-1:0] root;
    } sqs_t;

    // Restoring divider partial result.
    typedef struct packed {
        logic [34:0]          rem;
        logic [DIV_STEPS-1:0] q;
        logic                 full;
    } dstep_t;

    // One bit of the integer square root: keeps rem = radicand - root^2.
    function automatic sqs_t sqrt_step(input sqs_t s, input int b);
        logic [RAD_W:0] trial;
        sqs_t           r;
        trial = ((RAD_W+1)'(s.root) << (b + 1)) | ((RAD_W+1)'(1) << (2 * b));
        r = s;
        if ({1'b0, s.rem} >= trial)
        begin
            r.rem  = s.rem - trial[RAD_W-1:0];
            r.root = s.root | (ROOT_BITS'(1) << b);
        end
        return r;
    endfunction

    // Divider set-up: a numerator at or above the divisor gives exactly one.
    function automatic dstep_t div_load(input logic [32:0] num, input logic [33:0] den);
        dstep_t d;
        d.full = ({1'b0, num} >= den);
        d.rem  = 35'(num);
        d.q    = '0;
        return d;
    endfunction

    // One restoring division step.
    function automatic dstep_t div_step(input dstep_t d, input logic [33:0] den);
        logic [34:0] r2;
        dstep_t      n;
        r2 = {d.rem[33:0], 1'b0};
        n  = d;
        if (!d.full)
        begin
            if (r2 >= {1'b0, den})
            begin
                n.rem = r2 - {1'b0, den};
                n.q   = {d.q[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                n.rem = r2;
                n.q   = {d.q[DIV_STEPS-2:0], 1'b0};
            end
        end
        return n;
    endfunction

    // a * b / 2^30, truncated toward zero; |b| never exceeds one.
    function automatic logic signed [35:0] mul_q30(input logic signed [35:0] a,
                                                  input logic signed [31:0] b);
        logic [35:0] ma;
        logic [31:0] mb;
        logic [67:0] p;
        logic [35:0] r;
        ma = a[35] ? 36'(-a) : 36'(a);
        mb = b[31] ? 32'(-b) : 32'(b);
        p  = 68'(ma) * 68'(mb);
        r  = p[65:30];
        return (a[35] != b[31]) ? $signed(-r) : $signed(r);
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] r;
        if (v > 38'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -38'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### src/distance_constraint_solve_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance constraint solver core
// Restores the rest length of a strut between two 2-D point masses and removes
// their relative velocity along it, fully pipelined in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Channel  Direction  Carries
// s_axis   in         mode, both positions, velocities, masses, rest length
// m_axis   out        corrected positions and velocities
//
// One request is taken every cycle while the output is not stalled; each
// passes through three front-end stages, 34 square root stages, 31 divider
// stages and six product stages in series.
// Reset clears the stage valid bits only.
// A stall on the output holds every stage, the input included, so nothing
// moves until the waiting result has been taken.
// ----------------------------------------------------------------------------
module distance_constraint_solve_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x,
    // first_vel_y, second_vel_x, second_vel_y, first_mass, second_mass,
    // rest_length, zero fill
    input  logic [dcs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // new_first_pos_x, new_first_pos_y, new_second_pos_x, new_second_pos_y,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
    output logic [dcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import dcs_pkg::*;

    logic                     en;
    logic [N_STAGE-1:0]       vld_reg;
    ctx_t                     ctx_reg [N_STAGE];
    ctx_t                     in_ctx;
    ctx_t                     sel_ctx;

    logic signed [33:0]       dyn_reg [2];
    logic [65:0]              sqx_reg;
    logic [65:0]              sqy_reg;
    logic [65:0]              sqyn_reg;
    logic [32:0]              mag_dx;
    logic [32:0]              mag_dy;
    logic [32:0]              mag_dyn;
    logic [RAD_W-1:0]         sum_plain;
    logic [RAD_W-1:0]         sum_nudge;
    logic                     near;
    logic [RAD_W-1:0]         rad_reg;

    sqs_t                     sq_reg [ROOT_BITS];
    logic [33:0]              root_len;
    logic [16:0]              mass_sum;
    dstep_t                   dvx_reg [DIV_STEPS+1];
    dstep_t                   dvy_reg [DIV_STEPS+1];
    dstep_t                   dvw_reg [DIV_STEPS+1];
    logic [16:0]              msum_reg [DIV_STEPS+1];
    logic [33:0]              dist_reg [DIV_STEPS];

    logic [30:0]              qx;
    logic [30:0]              qy;
    logic [30:0]              qw;
    logic signed [31:0]       nx_reg [3];
    logic signed [31:0]       ny_reg [3];
    logic signed [31:0]       w1_reg [4];
    logic signed [31:0]       w2_reg [4];
    logic signed [32:0]       dvelx_reg;
    logic signed [32:0]       dvely_reg;
    logic signed [35:0]       tnx_reg;
    logic signed [35:0]       tny_reg;
    logic signed [35:0]       ax_reg;
    logic signed [35:0]       ay_reg;
    logic signed [35:0]       ex_reg;
    logic signed [35:0]       ey_reg;
    logic signed [35:0]       s_reg;
    logic signed [35:0]       cx1_reg;
    logic signed [35:0]       cy1_reg;
    logic signed [35:0]       cx2_reg;
    logic signed [35:0]       cy2_reg;
    logic signed [35:0]       ix_reg;
    logic signed [35:0]       iy_reg;
    logic signed [35:0]       gx1_reg;
    logic signed [35:0]       gy1_reg;
    logic signed [35:0]       gx2_reg;
    logic signed [35:0]       gy2_reg;
    logic [127:0]             pos_reg [2];
    logic [127:0]             vel_reg;

    // The whole pipeline advances unless a finished result is held.
    assign en            = !vld_reg[N_STAGE-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[N_STAGE-1];
    assign m_axis_tdata  = {vel_reg, pos_reg[1]};

    // Unpack the request and form the separation.
    always_comb
    begin
        in_ctx.mode = s_axis_tuser;
        in_ctx.p1x  = s_axis_tdata[31:0];
        in_ctx.p1y  = s_axis_tdata[63:32];
        in_ctx.p2x  = s_axis_tdata[95:64];
        in_ctx.p2y  = 33'($signed(s_axis_tdata[127:96]));
        in_ctx.v1x  = s_axis_tdata[159:128];
        in_ctx.v1y  = s_axis_tdata[191:160];
        in_ctx.v2x  = s_axis_tdata[223:192];
        in_ctx.v2y  = s_axis_tdata[255:224];
        in_ctx.m1   = s_axis_tdata[271:256];
        in_ctx.m2   = s_axis_tdata[287:272];
        in_ctx.len  = s_axis_tdata[318:288];
        in_ctx.dx   = 33'($signed(s_axis_tdata[95:64])) - 33'($signed(s_axis_tdata[31:0]));
        in_ctx.dy   = 34'($signed(s_axis_tdata[127:96])) - 34'($signed(s_axis_tdata[63:32]));
    end

    // Magnitudes for squaring, and the near-zero choice between the two sums.
    always_comb
    begin
        mag_dx    = ctx_reg[ST_A].dx[32] ? 33'(-ctx_reg[ST_A].dx) : 33'(ctx_reg[ST_A].dx);
        mag_dy    = ctx_reg[ST_A].dy[33] ? 33'(-ctx_reg[ST_A].dy) : 33'(ctx_reg[ST_A].dy);
        mag_dyn   = dyn_reg[0][33] ? 33'(-dyn_reg[0]) : 33'(dyn_reg[0]);
        sum_plain = RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
        sum_nudge = RAD_W'(sqx_reg) + RAD_W'(sqyn_reg);
        near      = (sum_plain < NEAR_SQ);
        sel_ctx   = ctx_reg[ST_B];
        if (near)
        begin
            sel_ctx.p2y = ctx_reg[ST_B].p2y + 33'(NUDGE_STEP);
            sel_ctx.dy  = dyn_reg[1];
        end
    end

    // Divider operands and recombined quotients.
    always_comb
    begin
        root_len = sq_reg[ROOT_BITS-1].root;
        mass_sum = 17'(ctx_reg[ST_DL-1].m1) + 17'(ctx_reg[ST_DL-1].m2);
        qx = dvx_reg[DIV_STEPS].full ? ONE_Q30 : {1'b0, dvx_reg[DIV_STEPS].q};
        qy = dvy_reg[DIV_STEPS].full ? ONE_Q30 : {1'b0, dvy_reg[DIV_STEPS].q};
        qw = dvw_reg[DIV_STEPS].full ? ONE_Q30 : {1'b0, dvw_reg[DIV_STEPS].q};
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N_STAGE-2:0], s_axis_tvalid};
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Context line, with the nudge applied at the selection stage.
            ctx_reg[0] <= in_ctx;
            for (int i = 1; i < N_STAGE; i++)
            begin
                if (i == ST_C)
                    ctx_reg[i] <= sel_ctx;
                else
                    ctx_reg[i] <= ctx_reg[i-1];
            end

            // Nudged separation, squares and radicand.
            dyn_reg[0] <= in_ctx.dy + NUDGE_STEP;
            dyn_reg[1] <= dyn_reg[0];
            sqx_reg    <= 66'(mag_dx) * 66'(mag_dx);
            sqy_reg    <= 66'(mag_dy) * 66'(mag_dy);
            sqyn_reg   <= 66'(mag_dyn) * 66'(mag_dyn);
            rad_reg    <= near ? sum_nudge : sum_plain;

            // Square root, one root bit per stage from the top.
            sq_reg[0] <= sqrt_step('{rem: rad_reg, root: '0}, ROOT_BITS - 1);
            for (int k = 1; k < ROOT_BITS; k++)
                sq_reg[k] <= sqrt_step(sq_reg[k-1], ROOT_BITS - 1 - k);

            // Direction and weight dividers, one quotient bit per stage.
            dvx_reg[0]  <= div_load(ctx_reg[ST_DL-1].dx[32] ? 33'(-ctx_reg[ST_DL-1].dx)
                                                            : 33'(ctx_reg[ST_DL-1].dx), root_len);
            dvy_reg[0]  <= div_load(ctx_reg[ST_DL-1].dy[33] ? 33'(-ctx_reg[ST_DL-1].dy)
                                                            : 33'(ctx_reg[ST_DL-1].dy), root_len);
            dvw_reg[0]  <= div_load(33'(ctx_reg[ST_DL-1].m2), 34'(mass_sum));
            msum_reg[0] <= mass_sum;
            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                dvx_reg[j]  <= div_step(dvx_reg[j-1], dist_reg[j-1]);
                dvy_reg[j]  <= div_step(dvy_reg[j-1], dist_reg[j-1]);
                dvw_reg[j]  <= div_step(dvw_reg[j-1], 34'(msum_reg[j-1]));
                msum_reg[j] <= msum_reg[j-1];
            end

            // Distance travelling alongside the dividers.
            dist_reg[0] <= root_len;
            for (int j = 1; j < DIV_STEPS; j++)
                dist_reg[j] <= dist_reg[j-1];

            // Signed direction, weights and velocity difference.
            nx_reg[0] <= ctx_reg[ST_P0-1].dx[32] ? -32'(qx) : 32'(qx);
            ny_reg[0] <= ctx_reg[ST_P0-1].dy[33] ? -32'(qy) : 32'(qy);
            if (ctx_reg[ST_P0-1].mode && (msum_reg[DIV_STEPS] != 17'd0))
            begin
                w1_reg[0] <= 32'(qw);
                w2_reg[0] <= dvw_reg[DIV_STEPS].full ? 32'sd0 :
                             32'(ONE_Q30) - 32'(qw) - 32'(dvw_reg[DIV_STEPS].rem != 35'd0);
            end
            else
            begin
                w1_reg[0] <= 32'(HALF_Q30);
                w2_reg[0] <= 32'(HALF_Q30);
            end
            dvelx_reg <= 33'(ctx_reg[ST_P0-1].v1x) - 33'(ctx_reg[ST_P0-1].v2x);
            dvely_reg <= 33'(ctx_reg[ST_P0-1].v1y) - 33'(ctx_reg[ST_P0-1].v2y);
            for (int k = 1; k < 3; k++)
            begin
                nx_reg[k] <= nx_reg[k-1];
                ny_reg[k] <= ny_reg[k-1];
            end
            for (int k = 1; k < 4; k++)
            begin
                w1_reg[k] <= w1_reg[k-1];
                w2_reg[k] <= w2_reg[k-1];
            end

            // Rest-length projection and velocity projections.
            tnx_reg <= mul_q30(36'(signed'({1'b0, ctx_reg[ST_P0].len})), nx_reg[0]);
            tny_reg <= mul_q30(36'(signed'({1'b0, ctx_reg[ST_P0].len})), ny_reg[0]);
            ax_reg  <= mul_q30(36'(dvelx_reg), nx_reg[0]);
            ay_reg  <= mul_q30(36'(dvely_reg), ny_reg[0]);

            // Length error and closing speed.
            ex_reg <= 36'(ctx_reg[ST_P0+1].dx) - tnx_reg;
            ey_reg <= 36'(ctx_reg[ST_P0+1].dy) - tny_reg;
            s_reg  <= ax_reg + ay_reg;

            // Weighted position corrections and the velocity impulse.
            cx1_reg <= mul_q30(ex_reg, w1_reg[2]);
            cy1_reg <= mul_q30(ey_reg, w1_reg[2]);
            cx2_reg <= mul_q30(ex_reg, w2_reg[2]);
            cy2_reg <= mul_q30(ey_reg, w2_reg[2]);
            ix_reg  <= mul_q30(s_reg, nx_reg[2]);
            iy_reg  <= mul_q30(s_reg, ny_reg[2]);

            // Corrected positions and weighted impulse.
            pos_reg[0] <= {sat32(38'(ctx_reg[ST_P0+3].p2y) - 38'(cy2_reg)),
                           sat32(38'(ctx_reg[ST_P0+3].p2x) - 38'(cx2_reg)),
                           sat32(38'(ctx_reg[ST_P0+3].p1y) + 38'(cy1_reg)),
                           sat32(38'(ctx_reg[ST_P0+3].p1x) + 38'(cx1_reg))};
            gx1_reg <= mul_q30(ix_reg, w1_reg[3]);
            gy1_reg <= mul_q30(iy_reg, w1_reg[3]);
            gx2_reg <= mul_q30(ix_reg, w2_reg[3]);
            gy2_reg <= mul_q30(iy_reg, w2_reg[3]);

            // Corrected velocities; this stage is the output register.
            pos_reg[1] <= pos_reg[0];
            vel_reg    <= {sat32(38'(ctx_reg[ST_P0+4].v2y) + 38'(gy2_reg)),
                           sat32(38'(ctx_reg[ST_P0+4].v2x) + 38'(gx2_reg)),
                           sat32(38'(ctx_reg[ST_P0+4].v1y) - 38'(gy1_reg)),
                           sat32(38'(ctx_reg[ST_P0+4].v1x) - 38'(gx1_reg))};
        end
    end

    // The nudge guarantees a usable divisor.
    a_dist_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DL-1] |-> (root_len >= NEAR_LIMIT))
        else $error("distance below the near-zero limit after the nudge");

    // The two weights never add up to more than one.
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_P0] |-> (33'(w1_reg[0]) + 33'(w2_reg[0]) <= 33'(ONE_Q30)))
        else $error("split weights exceed unity");

    // The unit direction stays within one on each axis.
    a_dir_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_P0] |-> ((nx_reg[0] <= 32'sd1073741824) && (nx_reg[0] >= -32'sd1073741824)
                         && (ny_reg[0] <= 32'sd1073741824) && (ny_reg[0] >= -32'sd1073741824)))
        else $error("direction component beyond unity");

endmodule

### tb/distance_constraint_solve_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance constraint solver core testbench
// Sends directed and random strut requests through the stream input, predicts
// the corrected positions and velocities of each one, and compares every
// output field in order, with random idling on both the sending and the
// receiving side.
// ----------------------------------------------------------------------------
module distance_constraint_solve_core_test;

    import dcs_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  DRAIN_CYCLES = 100;
    localparam bit  MODE_EQUAL   = 1'b0;
    localparam bit  MODE_MASS    = 1'b1;

    // One strut request as it is packed onto the input stream.
    typedef struct packed {
        logic               func;
        logic [30:0]        len;
        logic [15:0]        m2;
        logic [15:0]        m1;
        logic signed [31:0] v2y;
        logic signed [31:0] v2x;
        logic signed [31:0] v1y;
        logic signed [31:0] v1x;
        logic signed [31:0] p2y;
        logic signed [31:0] p2x;
        logic signed [31:0] p1y;
        logic signed [31:0] p1x;
    } strut_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [OUT_DATA_W-1:0] solved_q[$];
    int                    error_count = 0;
    int                    cycle_count = 0;

    distance_constraint_solve_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Magnitude of a wide signed value.
    function automatic logic [127:0] wide_mag(input logic signed [127:0] a);
        return a < 0 ? -a : a;
    endfunction

    // Product shifted right by 30 toward zero, with the 64-bit product width.
    function automatic logic signed [127:0] q30_product(input logic signed [127:0] a,
                                                        input logic signed [127:0] b);
        logic [127:0] p;
        p = wide_mag(a) * wide_mag(b);
        p = {64'd0, p[63:0]} >> 30;
        return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
    endfunction

    // Integer square root of the squared separation.
    function automatic logic [127:0] strut_length(input logic signed [127:0] dx,
                                                  input logic signed [127:0] dy);
        logic [127:0] sq;
        logic [127:0] root;
        logic [127:0] trial;
        sq   = wide_mag(dx) * wide_mag(dx) + wide_mag(dy) * wide_mag(dy);
        root = '0;
        for (int b = 34; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root;
    endfunction

    // Unit direction component in Q2.30, worked on magnitudes.
    function automatic logic signed [127:0] unit_component(input logic signed [127:0] num,
                                                           input logic [127:0] den);
        logic [127:0] rem;
        logic [127:0] q;
        rem = wide_mag(num);
        q   = '0;
        if (den == 0)
            return 0;
        if (rem >= den)
            q = 128'd1 << 30;
        else
        begin
            for (int i = 0; i < 30; i++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    q   = q | 128'd1;
                end
            end
        end
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -128'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Corrected positions and velocities for one strut request.
    function automatic logic [OUT_DATA_W-1:0] solve_strut(input strut_req_t r);
        logic signed [127:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, len;
        logic signed [127:0] dx, dy, nx, ny, ex, ey, w1, w2, s, ix, iy;
        logic [127:0]        sep_len;
        logic [127:0]        msum;
        p1x = r.p1x;
        p1y = r.p1y;
        p2x = r.p2x;
        p2y = r.p2y;
        v1x = r.v1x;
        v1y = r.v1y;
        v2x = r.v2x;
        v2y = r.v2y;
        len = {97'd0, r.len};
        dx      = p2x - p1x;
        dy      = p2y - p1y;
        sep_len = strut_length(dx, dy);
        // Coincident or nearly coincident bodies: lift the second one slightly.
        if (sep_len < 7)
        begin
            p2y     = p2y + 13;
            dy      = p2y - p1y;
            sep_len = strut_length(dx, dy);
        end
        nx = unit_component(dx, sep_len);
        ny = unit_component(dy, sep_len);
        ex = dx - q30_product(nx, len);
        ey = dy - q30_product(ny, len);
        w1 = 128'sd1 << 29;
        w2 = 128'sd1 << 29;
        msum = r.m1 + r.m2;
        if (r.func == MODE_MASS && msum != 0)
        begin
            w1 = ({112'd0, r.m2} << 30) / msum;
            w2 = ({112'd0, r.m1} << 30) / msum;
        end
        s  = q30_product(v1x - v2x, nx) + q30_product(v1y - v2y, ny);
        ix = q30_product(s, nx);
        iy = q30_product(s, ny);
        return {clamp32(v2y + q30_product(iy, w2)), clamp32(v2x + q30_product(ix, w2)),
                clamp32(v1y - q30_product(iy, w1)), clamp32(v1x - q30_product(ix, w1)),
                clamp32(p2y - q30_product(ey, w2)), clamp32(p2x - q30_product(ex, w2)),
                clamp32(p1y + q30_product(ey, w1)), clamp32(p1x + q30_product(ex, w1))};
    endfunction

    // Idling is switched off for a long stretch in the middle of the run.
    function automatic bit take_idle();
        if (cycle_count >= 1500 && cycle_count < 2500)
            return 1'b0;
        return $urandom_range(99) < 25;
    endfunction

    // Send one request and record its prediction once it is accepted.
    task automatic send_strut(input strut_req_t r);
        while (take_idle())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.len, r.m2, r.m1, r.v2y, r.v2x, r.v1y, r.v1x,
                          r.p2y, r.p2x, r.p1y, r.p1x};
        s_axis_tuser  <= r.func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        solved_q.push_back(solve_strut(r));
    endtask

    function automatic logic [31:0] rand_word();
        return $urandom;
    endfunction

    function automatic logic [15:0] rand_mass();
        return 16'($urandom_range(65535, 1));
    endfunction

    // Extremes, both modes, coincident and nearly coincident bodies.
    task automatic test_directed();
        strut_req_t r;
        r = '0;
        r.m1 = 16'h0100;
        r.m2 = 16'h0100;
        // Coincident bodies in both modes.
        send_strut(r);
        r.func = MODE_MASS;
        send_strut(r);
        // Nearly coincident bodies.
        r.p2x = 32'sd3;
        r.p2y = -32'sd2;
        send_strut(r);
        r.func = MODE_EQUAL;
        send_strut(r);
        // Exactly at the near-zero limit.
        r.p2x = 32'sd7;
        r.p2y = 32'sd0;
        send_strut(r);
        // Opposite corners with the extreme velocities and rest lengths.
        r.p1x = 32'h8000_0000;
        r.p1y = 32'h8000_0000;
        r.p2x = 32'h7FFF_FFFF;
        r.p2y = 32'h7FFF_FFFF;
        r.v1x = 32'h7FFF_FFFF;
        r.v1y = 32'h7FFF_FFFF;
        r.v2x = 32'h8000_0000;
        r.v2y = 32'h8000_0000;
        r.len = '0;
        send_strut(r);
        r.len = '1;
        send_strut(r);
        r.func = MODE_MASS;
        r.m1   = 16'd1;
        r.m2   = 16'hFFFF;
        send_strut(r);
        r.m1   = 16'hFFFF;
        r.m2   = 16'd1;
        r.len  = '0;
        send_strut(r);
        r.m1 = 16'hFFFF;
        r.m2 = 16'hFFFF;
        r.p1x = 32'h7FFF_FFFF;
        r.p2x = 32'h8000_0000;
        r.v1x = 32'h8000_0000;
        r.v2x = 32'h7FFF_FFFF;
        send_strut(r);
        // Unit length strut along each axis.
        r = '0;
        r.p2x  = 32'sh0002_0000;
        r.len  = 31'h0001_0000;
        r.v1x  = 32'sh0001_0000;
        r.m1   = 16'h0200;
        r.m2   = 16'h0100;
        send_strut(r);
        r.func = MODE_MASS;
        send_strut(r);
        r.p2x = '0;
        r.p2y = -32'sh0003_0000;
        r.v2y = 32'sh0000_8000;
        send_strut(r);
    endtask

    // Random requests: mostly struts of moderate size, some full-range noise.
    task automatic test_random(input int count);
        strut_req_t r;
        int         span;
        for (int n = 0; n < count; n++)
        begin
            r.func = 1'($urandom_range(1));
            r.m1   = rand_mass();
            r.m2   = rand_mass();
            if ($urandom_range(3) == 0)
            begin
                r.p1x = rand_word();
                r.p1y = rand_word();
                r.p2x = rand_word();
                r.p2y = rand_word();
                r.v1x = rand_word();
                r.v1y = rand_word();
                r.v2x = rand_word();
                r.v2y = rand_word();
                r.len = 31'($urandom);
            end
            else
            begin
                span  = 1 << $urandom_range(24, 2);
                r.p1x = $signed($urandom_range(2 * span)) - span;
                r.p1y = $signed($urandom_range(2 * span)) - span;
                r.p2x = r.p1x + ($signed($urandom_range(2 * span)) - span);
                r.p2y = r.p1y + ($signed($urandom_range(2 * span)) - span);
                r.v1x = $signed($urandom_range(2 * span)) - span;
                r.v1y = $signed($urandom_range(2 * span)) - span;
                r.v2x = $signed($urandom_range(2 * span)) - span;
                r.v2y = $signed($urandom_range(2 * span)) - span;
                r.len = 31'($urandom_range(2 * span));
            end
            send_strut(r);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Receiver stalls.
    always @(posedge clk)
    begin
        m_axis_tready <= !take_idle();
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        logic [OUT_DATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (solved_q.size() == 0)
            begin
                $display("%0t: result with none pending, actual %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = solved_q.pop_front();
                for (int f = 0; f < 8; f++)
                begin
                    if (m_axis_tdata[32*f +: 32] !== want[32*f +: 32])
                    begin
                        $display("%0t: field %0d expected %h actual %h", $time, f,
                                 want[32*f +: 32], m_axis_tdata[32*f +: 32]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        int drain;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1000);
        while (solved_q.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge clk);
        if (error_count == 0 && solved_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### distance_constraint_solve_core.f
src/dcs_pkg.sv
src/distance_constraint_solve_core.sv
tb/distance_constraint_solve_core_test.sv
